// ===== hw/rtl/cab_pkg.sv =====
// ----------------------------------------------------------------------------
// cab_pkg: shared types and constants for the constant-alpha pixel blend
// Pixel formats, register map, beat payload structs and config struct.
// ----------------------------------------------------------------------------
package cab_pkg;

  // Pixel format codes (pixel_format register)
  typedef enum logic [1:0] {
    FMT_RGB565   = 2'd0,
    FMT_RGBA5551 = 2'd1,
    FMT_RGBA4444 = 2'd2,
    FMT_RGBA8888 = 2'd3
  } pix_fmt_t;

  // Register map: byte address 4*i, index taken from paddr[2]
  localparam int unsigned ADDR_W = 3;
  typedef enum logic {
    REG_PIXEL_FORMAT = 1'b0,
    REG_BLEND_ALPHA  = 1'b1
  } reg_idx_t;

  // Reset values
  localparam pix_fmt_t   FMT_RESET   = FMT_RGBA8888;
  localparam logic [7:0] ALPHA_RESET = 8'hFF;

  // Alpha codes with special meaning
  localparam logic [7:0] ALPHA_COPY = 8'hFF;
  localparam logic [7:0] ALPHA_NONE = 8'h00;

  // Reciprocal of 15 for sums up to 225: q = (x * 137) >> 11
  localparam logic [7:0] RECIP15     = 8'd137;
  localparam int unsigned RECIP15_SH = 11;

  typedef struct packed {
    pix_fmt_t   pixel_format;
    logic [7:0] blend_alpha;
  } cab_cfg_t;

  typedef struct packed {
    logic [31:0] source_pixel;
    logic [31:0] dest_pixel;
  } pix_in_t;

  typedef struct packed {
    logic [31:0] blended_pixel;
    logic        write_enable;
  } pix_out_t;

endpackage

// ===== hw/rtl/cab_regs.sv =====
// ----------------------------------------------------------------------------
// cab_regs: configuration registers behind an APB-style port
// Holds pixel_format and blend_alpha; writes on the access phase.
// ----------------------------------------------------------------------------
module cab_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cab_pkg::ADDR_W-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output cab_pkg::cab_cfg_t             cfg
);
  import cab_pkg::*;

  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[2]);

  // register write
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pixel_format <= FMT_RESET;
      cfg.blend_alpha  <= ALPHA_RESET;
    end else if (wr_en) begin
      unique case (idx)
        REG_PIXEL_FORMAT: cfg.pixel_format <= pix_fmt_t'(pwdata[1:0]);
        REG_BLEND_ALPHA:  cfg.blend_alpha  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      REG_PIXEL_FORMAT: prdata = {30'd0, cfg.pixel_format};
      REG_BLEND_ALPHA:  prdata = {24'd0, cfg.blend_alpha};
      default:          prdata = 32'd0;
    endcase
  end

endmodule

// ===== hw/rtl/cab_blend.sv =====
// ----------------------------------------------------------------------------
// cab_blend: per-pixel blend datapath
// Channel weights for 565/5551/4444/8888, transparency test and alpha
// special cases; purely combinational between the pipeline registers.
// ----------------------------------------------------------------------------
module cab_blend (
  input  cab_pkg::cab_cfg_t cfg,
  input  cab_pkg::pix_in_t  item,
  output cab_pkg::pix_out_t result
);
  import cab_pkg::*;

  logic [31:0] s, d;
  logic [7:0]  a;

  assign s = item.source_pixel;
  assign d = item.dest_pixel;
  assign a = cfg.blend_alpha;

  // ---------------- rgb565 ----------------
  logic [5:0]  w6;
  logic [6:0]  v6;
  logic [4:0]  w5;
  logic [5:0]  v5;
  logic [9:0]  r565_sum, b565_sum;
  logic [11:0] g565_sum;
  logic [15:0] pix565;

  assign w6 = a[7:2];
  assign v6 = 7'd64 - {1'b0, w6};
  assign w5 = w6[5:1];
  assign v5 = v6[6:1];

  assign r565_sum = {5'd0, s[15:11]} * {4'd0, v5} + {5'd0, d[15:11]} * {5'd0, w5};
  assign g565_sum = {6'd0, s[10:5]} * {5'd0, v6} + {6'd0, d[10:5]} * {6'd0, w6};
  assign b565_sum = {5'd0, s[4:0]} * {4'd0, v5} + {5'd0, d[4:0]} * {5'd0, w5};
  assign pix565   = {r565_sum[9:5], g565_sum[11:6], b565_sum[9:5]};

  // ---------------- rgba5551 ----------------
  logic [4:0]  w51;
  logic [5:0]  v51;
  logic [9:0]  r51_sum, g51_sum, b51_sum;
  logic        a51;
  logic [15:0] pix5551;

  assign w51 = a[7:3];
  assign v51 = 6'd32 - {1'b0, w51};

  assign r51_sum = {5'd0, s[15:11]} * {4'd0, v51} + {5'd0, d[15:11]} * {5'd0, w51};
  assign g51_sum = {5'd0, s[10:6]}  * {4'd0, v51} + {5'd0, d[10:6]}  * {5'd0, w51};
  assign b51_sum = {5'd0, s[5:1]}   * {4'd0, v51} + {5'd0, d[5:1]}   * {5'd0, w51};
  // heavy destination weight keeps the destination's alpha bit
  assign a51     = w51[4] ? d[0] : s[0];
  assign pix5551 = {r51_sum[9:5], g51_sum[9:5], b51_sum[9:5], a51};

  // ---------------- rgba4444 ----------------
  logic [3:0]  w44;
  logic [3:0]  v44;
  logic [15:0] pix4444;

  assign w44 = a[7:4];
  assign v44 = 4'd15 - w44;

  // four independent nibble lanes, divide by 15 through reciprocal
  for (genvar k = 0; k < 4; k++) begin : g_lane44
    logic [7:0]  sum;
    logic [15:0] prod;
    assign sum  = {4'd0, s[4*k +: 4]} * {4'd0, v44} + {4'd0, d[4*k +: 4]} * {4'd0, w44};
    assign prod = {8'd0, sum} * {8'd0, RECIP15};
    assign pix4444[4*k +: 4] = prod[RECIP15_SH +: 4];
  end

  // ---------------- rgba8888 ----------------
  logic [7:0]  v88;
  logic [31:0] pix8888;

  assign v88 = 8'd255 - a;

  for (genvar k = 0; k < 4; k++) begin : g_lane88
    logic [15:0] sum;
    assign sum = {8'd0, s[8*k +: 8]} * {8'd0, v88} + {8'd0, d[8*k +: 8]} * {8'd0, a};
    assign pix8888[8*k +: 8] = sum[15:8];
  end

  // ---------------- result select ----------------
  always_comb begin
    result.blended_pixel = 32'd0;
    result.write_enable  = 1'b0;
    if (a == ALPHA_COPY) begin
      // plain copy, even for a transparent source
      result.write_enable = 1'b1;
      if (cfg.pixel_format == FMT_RGBA8888) begin
        result.blended_pixel = s;
      end else begin
        result.blended_pixel = {16'd0, s[15:0]};
      end
    end else if (a != ALPHA_NONE) begin
      unique case (cfg.pixel_format)
        FMT_RGB565: begin
          result.blended_pixel = {16'd0, pix565};
          result.write_enable  = 1'b1;
        end
        FMT_RGBA5551: begin
          if (s[0]) begin
            result.blended_pixel = {16'd0, pix5551};
            result.write_enable  = 1'b1;
          end
        end
        FMT_RGBA4444: begin
          if (s[3:0] != 4'd0) begin
            result.blended_pixel = {16'd0, pix4444};
            result.write_enable  = 1'b1;
          end
        end
        FMT_RGBA8888: begin
          if (s[31:24] != 8'd0) begin
            result.blended_pixel = pix8888;
            result.write_enable  = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/constant_alpha_pixel_blend_core.sv =====
// Path: an accepted input beat is held in the input register, then blended into
// the result register, where result_valid rises.
// Throughput: one pixel per cycle without result stalls; the blend sits between
// the input and result registers, so both sides may stall independently.
// Reset: rst clears both pipeline valids and sets pixel_format to rgba8888
// and blend_alpha to 255 (plain copy).
// ----------------------------------------------------------------------------
// constant_alpha_pixel_blend_core: constant-alpha pixel blend top level
// Input register, blend datapath, result register and APB config block.
// ----------------------------------------------------------------------------
module constant_alpha_pixel_blend_core (
  input  logic                          clk,
  input  logic                          rst,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cab_pkg::ADDR_W-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  // pixel input
  input  logic                          item_valid,
  output logic                          item_ready,
  input  cab_pkg::pix_in_t              item,
  // blend result
  output logic                          result_valid,
  input  logic                          result_ready,
  output cab_pkg::pix_out_t             result
);
  import cab_pkg::*;

  cab_cfg_t cfg;
  pix_in_t  stage_item;
  logic     stage_valid;
  logic     stage_advance;
  pix_out_t blend_out;

  cab_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // stage moves on when the result register is empty or being drained
  assign stage_advance = stage_valid && (!result_valid || result_ready);
  assign item_ready    = !stage_valid || stage_advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (item_ready) begin
      stage_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      stage_item <= item;
    end
  end

  cab_blend u_blend (
    .cfg    (cfg),
    .item   (stage_item),
    .result (blend_out)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (stage_advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_advance) begin
      result <= blend_out;
    end
  end

  // ---------------- assertions ----------------
  a_advance_fills: assert property (@(posedge clk) disable iff (rst)
    stage_advance |=> result_valid)
    else $error("result register not loaded after stage advance");

  a_empty_stage_ready: assert property (@(posedge clk) disable iff (rst)
    !stage_valid |-> item_ready)
    else $error("empty input stage refuses a beat");

  a_no_write_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.write_enable) |-> (result.blended_pixel == 32'd0))
    else $error("skipped write carries nonzero pixel");

  a_reset_clears: assert property (@(posedge clk)
    $past(rst) |-> (!result_valid && !stage_valid))
    else $error("pipeline valid set after reset");

endmodule

// ===== tb/blend_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blend_result_checker: scoreboard for the constant-alpha pixel blend
// Tracks the two registers from the configuration port and computes the blend
// result for every accepted input beat. Each result beat is checked, field by
// field, against the oldest result still waiting.
// ----------------------------------------------------------------------------
module blend_result_checker (
  input  logic                        clk,
  input  logic                        rst,
  // configuration port, observed only
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cab_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  input  logic                        pready,
  // pixel input channel
  input  logic                        item_valid,
  input  logic                        item_ready,
  input  cab_pkg::pix_in_t            item,
  // blend result channel
  input  logic                        result_valid,
  input  logic                        result_ready,
  input  cab_pkg::pix_out_t           result,
  // status for the test top
  output int                          fail_count,
  output int                          pending,
  output int                          results_checked,
  output int                          writes_seen
);
  import cab_pkg::*;

  // Shadow copy of the registers
  pix_fmt_t   shadow_fmt;
  logic [7:0] shadow_alpha;

  pix_out_t   expected_blends[$];
  pix_out_t   oldest;
  int         mismatches;
  int         checked;
  int         writes;

  // Weighted sum of one source and one destination channel
  function automatic int unsigned mix(input int unsigned sc, input int unsigned dc,
                                      input int unsigned ws, input int unsigned wd);
    return sc * ws + dc * wd;
  endfunction

  // Expected result of one pixel pair under the given format and alpha
  function automatic pix_out_t predict_blend(input pix_fmt_t fmt, input logic [7:0] alpha,
                                             input pix_in_t px);
    pix_out_t    res;
    logic [31:0] s;
    logic [31:0] d;
    int unsigned a;
    int unsigned w;
    int unsigned v;
    int unsigned w5;
    int unsigned v5;
    res = '0;
    s   = px.source_pixel;
    d   = px.dest_pixel;
    a   = alpha;
    // 16-bit formats ignore the upper half of both pixels
    if (fmt != FMT_RGBA8888) begin
      s[31:16] = '0;
      d[31:16] = '0;
    end
    if (alpha == ALPHA_COPY) begin
      // plain copy, even for a transparent source
      res.blended_pixel = s;
      res.write_enable  = 1'b1;
    end else if (alpha != ALPHA_NONE) begin
      case (fmt)
        FMT_RGB565: begin
          w  = a >> 2;
          v  = 64 - w;
          w5 = w >> 1;
          v5 = v >> 1;
          res.blended_pixel[15:11] = 5'(mix(s[15:11], d[15:11], v5, w5) >> 5);
          res.blended_pixel[10:5]  = 6'(mix(s[10:5], d[10:5], v, w) >> 6);
          res.blended_pixel[4:0]   = 5'(mix(s[4:0], d[4:0], v5, w5) >> 5);
          res.write_enable         = 1'b1;
        end
        FMT_RGBA5551: begin
          // alpha bit clear: transparent, nothing written
          if (s[0]) begin
            w = a >> 3;
            v = 32 - w;
            res.blended_pixel[15:11] = 5'(mix(s[15:11], d[15:11], v, w) >> 5);
            res.blended_pixel[10:6]  = 5'(mix(s[10:6], d[10:6], v, w) >> 5);
            res.blended_pixel[5:1]   = 5'(mix(s[5:1], d[5:1], v, w) >> 5);
            res.blended_pixel[0]     = (w > 15) ? d[0] : s[0];
            res.write_enable         = 1'b1;
          end
        end
        FMT_RGBA4444: begin
          if (s[3:0] != 4'h0) begin
            w = a >> 4;
            v = 15 - w;
            for (int k = 0; k < 4; k++)
              res.blended_pixel[4*k +: 4] = 4'(mix(s[4*k +: 4], d[4*k +: 4], v, w) / 15);
            res.write_enable = 1'b1;
          end
        end
        default: begin
          if (s[31:24] != 8'h00) begin
            v = 255 - a;
            for (int k = 0; k < 4; k++)
              res.blended_pixel[8*k +: 8] = 8'(mix(s[8*k +: 8], d[8*k +: 8], v, a) >> 8);
            res.write_enable = 1'b1;
          end
        end
      endcase
    end
    return res;
  endfunction

  // Track registers, queue predictions, compare result beats
  always @(posedge clk) begin
    if (rst) begin
      shadow_fmt   = FMT_RESET;
      shadow_alpha = ALPHA_RESET;
      expected_blends.delete();
      mismatches   = 0;
      checked      = 0;
      writes       = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[2]))
          REG_PIXEL_FORMAT: shadow_fmt   = pix_fmt_t'(pwdata[1:0]);
          REG_BLEND_ALPHA:  shadow_alpha = pwdata[7:0];
          default: ;
        endcase
      end
      // result beat first, so a beat taken in this cycle is never matched
      if (result_valid && result_ready) begin
        checked++;
        if (result.write_enable === 1'b1)
          writes++;
        if (expected_blends.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result beat with nothing expected: pixel %h write %b",
                     $realtime, result.blended_pixel, result.write_enable);
        end else begin
          oldest = expected_blends.pop_front();
          if (result.blended_pixel !== oldest.blended_pixel ||
              result.write_enable !== oldest.write_enable) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: blend mismatch: expected pixel %h write %b, got pixel %h write %b",
                       $realtime, oldest.blended_pixel, oldest.write_enable,
                       result.blended_pixel, result.write_enable);
          end
        end
      end
      if (item_valid && item_ready)
        expected_blends.push_back(predict_blend(shadow_fmt, shadow_alpha, item));
    end
    fail_count      <= mismatches;
    pending         <= expected_blends.size();
    results_checked <= checked;
    writes_seen     <= writes;
  end

endmodule

// ===== tb/tb_constant_alpha_pixel_blend_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_constant_alpha_pixel_blend_core: test top for the pixel blend core
// Drives pixel beats and register writes, stalls the result side on its own
// pattern and gives the verdict. Checking is done by blend_result_checker.
// ----------------------------------------------------------------------------
module tb_constant_alpha_pixel_blend_core;
  import cab_pkg::*;

  localparam int PIPE_LATENCY    = 2;
  localparam int SETTLE_CYCLES   = 2 * PIPE_LATENCY + 2;
  localparam int PHASES          = 14;
  localparam int PHASE_BEATS     = 90;
  localparam int PRESSURE_PHASE  = 5;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int WATCHDOG_LIMIT  = 2000;

  logic              clk;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              item_valid = 1'b0;
  logic              item_ready;
  pix_in_t           item = '0;
  logic              result_valid;
  logic              result_ready = 1'b0;
  pix_out_t          result;

  int                fail_count;
  int                pending;
  int                results_checked;
  int                writes_seen;
  int                beats_sent = 0;
  int                settings_applied = 0;
  int                stall_cycles = 0;
  bit                hold_req = 1'b0;
  pix_fmt_t          cur_fmt = FMT_RESET;
  logic [7:0]        cur_alpha = ALPHA_RESET;

  constant_alpha_pixel_blend_core u_top (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  blend_result_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .pready          (pready),
    .item_valid      (item_valid),
    .item_ready      (item_ready),
    .item            (item),
    .result_valid    (result_valid),
    .result_ready    (result_ready),
    .result          (result),
    .fail_count      (fail_count),
    .pending         (pending),
    .results_checked (results_checked),
    .writes_seen     (writes_seen)
  );

  // Clock and reset
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
  end

  // Watchdog: cycles without any beat on either channel
  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $realtime, stall_cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result side: random ready pattern in segments, plus requested hold-offs
  initial begin : result_sink
    int seg_left;
    int mode;
    seg_left = 0;
    mode     = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        result_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      if (seg_left == 0) begin
        seg_left = $urandom_range(20, 150);
        mode     = $urandom_range(0, 3);
      end
      seg_left--;
      case (mode)
        0:       result_ready <= 1'b1;
        1:       result_ready <= 1'($urandom_range(0, 1));
        2:       result_ready <= ($urandom_range(0, 3) != 0);
        default: result_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // One register write: setup cycle, then access cycle
  task automatic apb_write(input reg_idx_t idx, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Offer one pixel beat and hold it until taken
  task automatic send_beat(input pix_in_t px);
    item       <= px;
    item_valid <= 1'b1;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    beats_sent++;
  endtask

  // Stop offering and wait until every result has come back
  task automatic wait_idle();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // New format and alpha, written only with the pipeline empty
  task automatic set_config(input pix_fmt_t fmt, input logic [7:0] alpha);
    wait_idle();
    apb_write(REG_PIXEL_FORMAT, 32'(fmt));
    apb_write(REG_BLEND_ALPHA, 32'(alpha));
    cur_fmt   = fmt;
    cur_alpha = alpha;
    settings_applied++;
  endtask

  // Directed beat; reconfigures first if the setting differs
  task automatic directed_beat(input pix_fmt_t fmt, input logic [7:0] alpha,
                               input logic [31:0] src, input logic [31:0] dst);
    if (fmt != cur_fmt || alpha != cur_alpha)
      set_config(fmt, alpha);
    send_beat('{source_pixel: src, dest_pixel: dst});
  endtask

  // Random pixel pair, biased toward flat and transparent sources
  function automatic pix_in_t random_pixels(input pix_fmt_t fmt);
    pix_in_t px;
    px.source_pixel = $urandom;
    px.dest_pixel   = $urandom;
    case ($urandom_range(0, 9))
      0: px.source_pixel = '0;
      1: px.source_pixel = '1;
      2: px.dest_pixel   = ($urandom_range(0, 1) != 0) ? '1 : '0;
      3: begin
        case (fmt)
          FMT_RGBA5551: px.source_pixel[0]     = 1'b0;
          FMT_RGBA4444: px.source_pixel[3:0]   = 4'h0;
          FMT_RGBA8888: px.source_pixel[31:24] = 8'h00;
          default: ;
        endcase
      end
      default: ;
    endcase
    return px;
  endfunction

  // Phase alpha with the edges favored
  function automatic logic [7:0] random_alpha();
    case ($urandom_range(0, 7))
      0:       return ALPHA_NONE;
      1:       return ALPHA_COPY;
      2:       return 8'd1;
      3:       return 8'd254;
      default: return 8'($urandom_range(2, 253));
    endcase
  endfunction

  // Stimulus and verdict
  initial begin : stimulus
    pix_fmt_t   fmt;
    logic [7:0] alpha;
    int         n;
    int         burst;
    bit         pressure;

    while (rst) @(posedge clk);

    // reset setting: rgba8888 with plain copy
    directed_beat(FMT_RGBA8888, ALPHA_COPY, 32'h0000_0000, 32'hFFFF_FFFF);
    directed_beat(FMT_RGBA8888, ALPHA_COPY, 32'h0012_3456, 32'hFFFF_FFFF);
    directed_beat(FMT_RGBA8888, ALPHA_NONE, 32'hFFFF_FFFF, 32'h1234_5678);
    directed_beat(FMT_RGBA8888, 8'd128,     32'hFFFF_FFFF, 32'h0000_0000);
    directed_beat(FMT_RGBA8888, 8'd128,     32'h00FF_FFFF, 32'hFFFF_FFFF);
    directed_beat(FMT_RGBA8888, 8'd1,       32'hFF00_FF00, 32'h00FF_00FF);
    directed_beat(FMT_RGBA8888, 8'd254,     32'h80FF_FFFF, 32'hFFFF_FFFF);
    // rgb565: upper halves ignored, source never transparent
    directed_beat(FMT_RGB565,   8'd128,     32'hFFFF_FFFF, 32'h0000_0000);
    directed_beat(FMT_RGB565,   8'd1,       32'h0000_FFFF, 32'h0000_FFFF);
    directed_beat(FMT_RGB565,   8'd254,     32'h0000_F81F, 32'hFFFF_07E0);
    directed_beat(FMT_RGB565,   ALPHA_COPY, 32'hABCD_1234, 32'h5555_5555);
    directed_beat(FMT_RGB565,   ALPHA_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // rgba5551: alpha bit follows the weight across the midpoint
    directed_beat(FMT_RGBA5551, 8'd128,     32'h0000_FFFF, 32'h0000_FFFE);
    directed_beat(FMT_RGBA5551, 8'd127,     32'h0000_0001, 32'hFFFF_FFFE);
    directed_beat(FMT_RGBA5551, 8'd100,     32'h0000_FFFE, 32'h0000_FFFF);
    directed_beat(FMT_RGBA5551, ALPHA_COPY, 32'h1234_0000, 32'hFFFF_FFFF);
    directed_beat(FMT_RGBA5551, 8'd7,       32'h0000_FFFF, 32'h0000_0000);
    // rgba4444: weights 0 and 15, transparent nibble
    directed_beat(FMT_RGBA4444, 8'd128,     32'hFFFF_FFFF, 32'h0000_0000);
    directed_beat(FMT_RGBA4444, 8'd15,      32'h0000_1231, 32'h0000_FFFF);
    directed_beat(FMT_RGBA4444, 8'd254,     32'h0000_000F, 32'hFFFF_FFFF);
    directed_beat(FMT_RGBA4444, 8'd200,     32'h0000_FFF0, 32'h0000_1111);
    directed_beat(FMT_RGBA4444, ALPHA_NONE, 32'h0000_FFFF, 32'h0000_FFFF);
    directed_beat(FMT_RGBA4444, ALPHA_COPY, 32'hFFFF_0000, 32'h0000_FFFF);

    // random phases, each with its own setting
    for (int p = 0; p < PHASES; p++) begin
      fmt      = pix_fmt_t'(p % 4);
      alpha    = random_alpha();
      pressure = (p == PRESSURE_PHASE);
      set_config(fmt, alpha);
      if (pressure)
        hold_req = 1'b1;
      n = 0;
      while (n < PHASE_BEATS) begin
        burst = $urandom_range(1, 24);
        for (int i = 0; i < burst && n < PHASE_BEATS; i++) begin
          send_beat(random_pixels(fmt));
          n++;
        end
        if (!pressure && $urandom_range(0, 3) != 0) begin
          item_valid <= 1'b0;
          repeat ($urandom_range(1, 6)) @(posedge clk);
        end
      end
    end

    wait_idle();
    $display("Covered %0d pixel beats under %0d register settings in all four formats.",
             beats_sent, settings_applied);
    $display("%0d result beats checked, %0d of them with the write flag set.",
             results_checked, writes_seen);
    if (fail_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
